// File: src/lc3x_pkg.sv
// Shared types, codes and helpers for the LC-3 executor.
package lc3x_pkg;

	// Input item selector (tuser on the input side)
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_STEP    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// Result kinds (tuser on the output side)
	localparam logic [1:0] KIND_DONE    = 2'd0;
	localparam logic [1:0] KIND_DUMP    = 2'd1;
	localparam logic [1:0] KIND_ILLEGAL = 2'd2;
	localparam logic [1:0] KIND_HALTED  = 2'd3;

	// Opcodes
	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LD   = 4'd2;
	localparam logic [3:0] OP_ST   = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDR  = 4'd6;
	localparam logic [3:0] OP_STR  = 4'd7;
	localparam logic [3:0] OP_RTI  = 4'd8;
	localparam logic [3:0] OP_NOT  = 4'd9;
	localparam logic [3:0] OP_LDI  = 4'd10;
	localparam logic [3:0] OP_STI  = 4'd11;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_RES  = 4'd13;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [7:0]  HALT_VECTOR  = 8'd37;
	localparam logic [15:0] FILL_WORD    = 16'h7777;
	localparam logic [15:0] START_PC_RST = 16'h3000;
	localparam logic [2:0]  REG_LAST     = 3'd7;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_EXEC,
		ST_MEM1,
		ST_MEM2,
		ST_RESP,
		ST_DUMP_RD,
		ST_DUMP_WR
	} lc3x_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic       accept;
		logic       clr;
		logic       fetch;
		logic       decode;
		logic       exec;
		logic       mem1;
		logic       mem2;
		logic       resp;
		logic [1:0] resp_kind;
		logic       dump_rd;
		logic       dump_wr;
	} lc3x_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic       clr_last;
		logic       halted;
		logic [3:0] opcode;
		logic       trap_halt;
		logic       out_free;
		logic       dump_last;
	} lc3x_sts_t;

	// n/z/p from a written value
	function automatic logic [2:0] cc_of(input logic [15:0] v);
		logic [2:0] cc;
		if (v[15]) begin
			cc = 3'b100;
		end else if (v == 16'd0) begin
			cc = 3'b010;
		end else begin
			cc = 3'b001;
		end
		return cc;
	endfunction

endpackage

// File: src/lc3x_ctrl.sv
// Sequencing state machine of the LC-3 executor.
module lc3x_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_mode,
	output logic                  in_ready,
	input  lc3x_pkg::lc3x_sts_t   sts,
	output lc3x_pkg::lc3x_cmd_t   cmd
);
	import lc3x_pkg::*;

	lc3x_state_t state_q;
	lc3x_state_t state_nxt;
	logic [1:0]  kind_q;
	logic        illegal;

	assign illegal = (sts.opcode == OP_RTI) || (sts.opcode == OP_RES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			kind_q  <= KIND_DONE;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && in_valid && in_mode == MODE_STEP) begin
				kind_q <= KIND_HALTED;
			end else if (state_q == ST_EXEC) begin
				kind_q <= illegal ? KIND_ILLEGAL : KIND_DONE;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && in_mode == MODE_STEP) begin
					state_nxt = sts.halted ? ST_RESP : ST_FETCH;
				end
			end
			ST_FETCH:  state_nxt = ST_DECODE;
			ST_DECODE: state_nxt = ST_EXEC;
			ST_EXEC: begin
				if (sts.opcode == OP_LD || sts.opcode == OP_LDR ||
				    sts.opcode == OP_LDI || sts.opcode == OP_STI) begin
					state_nxt = ST_MEM1;
				end else if (sts.opcode == OP_TRAP && sts.trap_halt) begin
					state_nxt = ST_DUMP_RD;
				end else begin
					state_nxt = ST_RESP;
				end
			end
			ST_MEM1: state_nxt = (sts.opcode == OP_LDI) ? ST_MEM2 : ST_RESP;
			ST_MEM2: state_nxt = ST_RESP;
			ST_RESP: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			ST_DUMP_RD: state_nxt = ST_DUMP_WR;
			ST_DUMP_WR: begin
				if (sts.out_free) state_nxt = sts.dump_last ? ST_IDLE : ST_DUMP_RD;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.clr       = (state_q == ST_CLEAR);
		cmd.fetch     = (state_q == ST_FETCH);
		cmd.decode    = (state_q == ST_DECODE);
		cmd.exec      = (state_q == ST_EXEC);
		cmd.mem1      = (state_q == ST_MEM1);
		cmd.mem2      = (state_q == ST_MEM2);
		cmd.resp      = (state_q == ST_RESP) && sts.out_free;
		cmd.resp_kind = kind_q;
		cmd.dump_rd   = (state_q == ST_DUMP_RD);
		cmd.dump_wr   = (state_q == ST_DUMP_WR) && sts.out_free;
	end

	// a halted core never fetches
	a_no_fetch_halted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> !sts.halted)
		else $error("fetch while halted");

endmodule

// File: src/lc3x_dp.sv
// Datapath of the LC-3 executor: memory, register file, pc, cc and result register.
module lc3x_dp #(
	parameter int ADDR_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lc3x_pkg::lc3x_cmd_t cmd,
	output lc3x_pkg::lc3x_sts_t sts,
	input  logic [1:0]          in_mode,
	input  logic [15:0]         load_address,
	input  logic [15:0]         load_data,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_kind,
	output logic [15:0]         out_pc,
	output logic [2:0]          out_cc,
	output logic [2:0]          out_idx,
	output logic [15:0]         out_val,
	output logic                out_last
);
	import lc3x_pkg::*;

	localparam int MemWords = 2 ** ADDR_BITS;

	logic [15:0] mem [MemWords];
	logic [15:0] mem_q;
	logic [15:0] rf_q [8];
	logic [15:0] ir_q;
	logic [15:0] base_q;
	logic [15:0] src_q;
	logic [15:0] pc_q;
	logic [2:0]  cc_q;
	logic        halted_q;
	logic [15:0] start_pc_q;
	logic [ADDR_BITS-1:0] clr_cnt_q;
	logic [2:0]  dump_cnt_q;
	logic        out_valid_q;

	logic [3:0]  op;
	logic [2:0]  dr;
	logic [15:0] imm5_x, off6_x, off9_x, off11_x;
	logic [15:0] op2, alu;
	logic [15:0] pc_off9, pc_off11, base_off6;
	logic [3:0]  dec_op;
	logic [2:0]  rdb_addr;

	logic        wr_en, rd_en;
	logic [15:0] wr_addr, wr_data, rd_addr;
	logic        rf_we, cc_we;
	logic [2:0]  rf_wa;
	logic [15:0] rf_wd;

	assign op       = ir_q[15:12];
	assign dr       = ir_q[11:9];
	assign imm5_x   = {{11{ir_q[4]}}, ir_q[4:0]};
	assign off6_x   = {{10{ir_q[5]}}, ir_q[5:0]};
	assign off9_x   = {{7{ir_q[8]}}, ir_q[8:0]};
	assign off11_x  = {{5{ir_q[10]}}, ir_q[10:0]};
	assign op2      = ir_q[5] ? imm5_x : src_q;
	assign pc_off9  = pc_q + off9_x;
	assign pc_off11 = pc_q + off11_x;
	assign base_off6 = base_q + off6_x;

	always_comb begin
		unique case (op)
			OP_ADD:  alu = base_q + op2;
			OP_AND:  alu = base_q & op2;
			default: alu = ~base_q;
		endcase
	end

	// second read port: stores read their source through dr
	assign dec_op   = mem_q[15:12];
	assign rdb_addr = (dec_op == OP_ST || dec_op == OP_STR || dec_op == OP_STI) ?
		mem_q[11:9] : mem_q[2:0];

	// memory port steering
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pc_q;
		wr_data = src_q;
		priority if (cmd.clr) begin
			wr_en   = 1'b1;
			wr_addr = 16'(clr_cnt_q);
			wr_data = FILL_WORD;
		end else if (cmd.accept && in_mode == MODE_LOAD) begin
			wr_en   = 1'b1;
			wr_addr = load_address;
			wr_data = load_data;
		end else if (cmd.exec && op == OP_ST) begin
			wr_en   = 1'b1;
			wr_addr = pc_off9;
		end else if (cmd.exec && op == OP_STR) begin
			wr_en   = 1'b1;
			wr_addr = base_off6;
		end else if (cmd.mem1 && op == OP_STI) begin
			wr_en   = 1'b1;
			wr_addr = mem_q;
		end else begin
			wr_en   = 1'b0;
		end
	end

	always_comb begin
		rd_en   = cmd.fetch || cmd.exec || cmd.mem1;
		rd_addr = pc_q;
		if (cmd.exec) begin
			rd_addr = (op == OP_LDR) ? base_off6 : pc_off9;
		end else if (cmd.mem1) begin
			rd_addr = mem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr[ADDR_BITS-1:0]] <= wr_data;
		if (rd_en) mem_q <= mem[rd_addr[ADDR_BITS-1:0]];
	end

	// register file write port
	always_comb begin
		rf_we = 1'b0;
		cc_we = 1'b0;
		rf_wa = dr;
		rf_wd = alu;
		if (cmd.exec) begin
			if (op == OP_ADD || op == OP_AND || op == OP_NOT) begin
				rf_we = 1'b1;
				cc_we = 1'b1;
			end else if (op == OP_LEA) begin
				rf_we = 1'b1;
				rf_wd = pc_off9;
			end else if (op == OP_JSR) begin
				rf_we = 1'b1;
				rf_wa = REG_LAST;
				rf_wd = pc_q;
			end
		end else if ((cmd.mem1 && (op == OP_LD || op == OP_LDR)) || cmd.mem2) begin
			rf_we = 1'b1;
			cc_we = 1'b1;
			rf_wd = mem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) rf_q[i] <= FILL_WORD;
		end else if (rf_we) begin
			rf_q[rf_wa] <= rf_wd;
		end
	end

	// registered register-file reads, instruction latch
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			ir_q   <= mem_q;
			base_q <= rf_q[mem_q[8:6]];
			src_q  <= rf_q[rdb_addr];
		end else if (cmd.dump_rd) begin
			base_q <= rf_q[dump_cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= 16'd0;
			cc_q       <= 3'b000;
			halted_q   <= 1'b0;
			start_pc_q <= START_PC_RST;
			clr_cnt_q  <= '0;
			dump_cnt_q <= 3'd0;
		end else begin
			if (cfg_wr_en) start_pc_q <= cfg_wr_data;
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cc_we) cc_q <= cc_of(rf_wd);
			if (cmd.dump_wr) dump_cnt_q <= dump_cnt_q + 3'd1;
			if (cmd.accept && in_mode == MODE_RESTART) begin
				pc_q     <= start_pc_q;
				halted_q <= 1'b0;
			end else if (cmd.fetch) begin
				pc_q <= pc_q + 16'd1;
			end else if (cmd.exec) begin
				if (op == OP_BR && (dr & cc_q) != 3'b000) begin
					pc_q <= pc_off9;
				end else if (op == OP_JSR) begin
					pc_q <= ir_q[11] ? pc_off11 : base_q;
				end else if (op == OP_JMP) begin
					pc_q <= base_q;
				end else if (op == OP_TRAP && ir_q[7:0] == HALT_VECTOR) begin
					halted_q   <= 1'b1;
					dump_cnt_q <= 3'd0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp || cmd.dump_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			out_kind <= cmd.resp_kind;
			out_pc   <= pc_q;
			out_cc   <= cc_q;
			out_idx  <= 3'd0;
			out_val  <= 16'd0;
			out_last <= 1'b1;
		end else if (cmd.dump_wr) begin
			out_kind <= KIND_DUMP;
			out_pc   <= pc_q;
			out_cc   <= cc_q;
			out_idx  <= dump_cnt_q;
			out_val  <= base_q;
			out_last <= (dump_cnt_q == REG_LAST);
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts           = '0;
		sts.clr_last  = &clr_cnt_q;
		sts.halted    = halted_q;
		sts.opcode    = op;
		sts.trap_halt = (ir_q[7:0] == HALT_VECTOR);
		sts.out_free  = !out_valid_q || out_ready;
		sts.dump_last = (dump_cnt_q == REG_LAST);
	end

	// never overwrite a result still waiting downstream
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.resp || cmd.dump_wr) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// dump entries only come from a halted core
	a_dump_halted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dump_wr |-> halted_q)
		else $error("dump while running");

	// a halt starts the dump at R0
	a_dump_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halted_q) |-> (dump_cnt_q == 3'd0))
		else $error("dump counter not cleared on halt");

endmodule

// File: src/lc3_instruction_executor.sv
// Top level of the LC-3 executor: controller plus datapath behind stream ports.
//
//  channel   dir  handshake                    payload
//  cfg       in   cfg_wr_en                    cfg_wr_data = start_pc
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser = mode, tdata = load_address, load_data
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser = kind, tlast = last,
//                                              tdata = pc_now, cond_codes, reg_index, reg_value
//
// After reset the word memory is swept to 0x7777, one word a cycle, all 2**ADDR_BITS words;
// s_axis_tready stays low during the sweep, start_pc writes are taken throughout.
// One item at a time: load, restart and unused-mode items are taken in idle. A step runs
// fetch, decode, execute and respond for ALU, branch, jump, LEA, ST and STR; LD, LDR and
// STI add mem1, LDI adds mem1 and mem2; a step while halted goes straight to respond.
// TRAP x25 then emits eight register entries, each read, then written out. The word memory
// has a write port and a registered read port; every fetch and data read goes through it.
// A stalled m_axis holds the result register; input is still accepted while a result
// waits, and the core stalls only in a state that must load a new result.
module lc3_instruction_executor #(
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,   // start_pc
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] load_address, [31:16] load_data
	input  logic [1:0]  s_axis_tuser,  // [1:0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [15:0] pc_now, [18:16] cond_codes,
	                                   // [21:19] reg_index, [37:22] reg_value, [39:38] zero
	output logic [1:0]  m_axis_tuser,  // [1:0] kind
	output logic        m_axis_tlast   // last
);
	import lc3x_pkg::*;

	lc3x_cmd_t   cmd;
	lc3x_sts_t   sts;
	logic [1:0]  out_kind;
	logic [15:0] out_pc;
	logic [2:0]  out_cc;
	logic [2:0]  out_idx;
	logic [15:0] out_val;

	lc3x_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lc3x_dp #(
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_mode      (s_axis_tuser),
		.load_address (s_axis_tdata[15:0]),
		.load_data    (s_axis_tdata[31:16]),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_kind     (out_kind),
		.out_pc       (out_pc),
		.out_cc       (out_cc),
		.out_idx      (out_idx),
		.out_val      (out_val),
		.out_last     (m_axis_tlast)
	);

	// pack result fields, lowest bit first
	assign m_axis_tdata = {2'b00, out_val, out_idx, out_cc, out_pc};
	assign m_axis_tuser = out_kind;

endmodule

// File: tb/lc3_instruction_executor_checker.sv
// Result checker for the LC-3 executor: shadows core state, predicts and compares results.
module lc3_instruction_executor_checker #(
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending
);
	import lc3x_pkg::*;

	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pc_now;
		logic [2:0]  cond_codes;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        last;
	} exec_result_t;

	exec_result_t due_results[$];

	// shadow of the core
	logic [15:0] mem_words [0:MEM_DEPTH-1];
	logic [15:0] gpr [0:7];
	logic [15:0] pc_q;
	logic [2:0]  nzp_q;
	logic        halted_q;
	logic [15:0] start_pc_q;

	function automatic logic [ADDR_BITS-1:0] wrap(input logic [15:0] a);
		return a[ADDR_BITS-1:0];
	endfunction

	function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
		logic signed [15:0] t;
		t = v << (16 - bits);
		return t >>> (16 - bits);
	endfunction

	function automatic void write_reg(input logic [2:0] r, input logic [15:0] v);
		gpr[r] = v;
		if (v[15]) begin
			nzp_q = 3'b100;
		end else if (v == 16'd0) begin
			nzp_q = 3'b010;
		end else begin
			nzp_q = 3'b001;
		end
	endfunction

	function automatic void push_result(input logic [1:0] kind, input logic [2:0] idx,
			input logic [15:0] val, input logic last);
		exec_result_t r;
		r.kind = kind;
		r.pc_now = pc_q;
		r.cond_codes = nzp_q;
		r.reg_index = idx;
		r.reg_value = val;
		r.last = last;
		due_results.push_back(r);
	endfunction

	task automatic reset_model();
		int a;
		for (a = 0; a < MEM_DEPTH; a++) begin
			mem_words[a] = FILL_WORD;
		end
		for (a = 0; a < 8; a++) begin
			gpr[a] = FILL_WORD;
		end
		pc_q = 16'd0;
		nzp_q = 3'b000;
		halted_q = 1'b0;
		start_pc_q = START_PC_RST;
		due_results.delete();
	endtask

	// fetch, bump pc, execute one word
	task automatic execute_step();
		logic [15:0] ir;
		logic [15:0] base;
		logic [15:0] op2;
		logic [15:0] ptr;
		logic [15:0] ret;
		logic [2:0]  dr;
		logic [1:0]  kind;
		logic        dumped;
		int          i;
		kind = KIND_DONE;
		dumped = 1'b0;
		if (halted_q) begin
			push_result(KIND_HALTED, 3'd0, 16'd0, 1'b1);
		end else begin
			ir = mem_words[wrap(pc_q)];
			pc_q = pc_q + 16'd1;
			dr = ir[11:9];
			base = gpr[ir[8:6]];
			op2 = ir[5] ? sext(ir, 5) : gpr[ir[2:0]];
			case (ir[15:12])
				OP_BR: begin
					if ((ir[11:9] & nzp_q) != 3'b000) begin
						pc_q = pc_q + sext(ir, 9);
					end
				end
				OP_ADD: write_reg(dr, base + op2);
				OP_AND: write_reg(dr, base & op2);
				OP_NOT: write_reg(dr, ~base);
				OP_LD:  write_reg(dr, mem_words[wrap(pc_q + sext(ir, 9))]);
				OP_LDI: begin
					ptr = mem_words[wrap(pc_q + sext(ir, 9))];
					write_reg(dr, mem_words[wrap(ptr)]);
				end
				OP_LDR: write_reg(dr, mem_words[wrap(base + sext(ir, 6))]);
				OP_ST:  mem_words[wrap(pc_q + sext(ir, 9))] = gpr[dr];
				OP_STI: begin
					ptr = mem_words[wrap(pc_q + sext(ir, 9))];
					mem_words[wrap(ptr)] = gpr[dr];
				end
				OP_STR: mem_words[wrap(base + sext(ir, 6))] = gpr[dr];
				OP_JSR: begin
					// target comes from the old register file, so JSRR R7 works
					ret = pc_q;
					pc_q = ir[11] ? pc_q + sext(ir, 11) : base;
					gpr[7] = ret;
				end
				OP_JMP: pc_q = base;
				OP_LEA: gpr[dr] = pc_q + sext(ir, 9);
				OP_TRAP: begin
					if (ir[7:0] == HALT_VECTOR) begin
						halted_q = 1'b1;
						dumped = 1'b1;
						for (i = 0; i < 8; i++) begin
							push_result(KIND_DUMP, i[2:0], gpr[i], i[2:0] == REG_LAST);
						end
					end
				end
				default: kind = KIND_ILLEGAL;
			endcase
			if (!dumped) begin
				push_result(kind, 3'd0, 16'd0, 1'b1);
			end
		end
	endtask

	task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
		$display("%0t: %s got %h, expected %h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic check_result();
		exec_result_t want;
		if (due_results.size() == 0) begin
			report("unexpected item, tdata", m_axis_tdata, 40'd0);
		end else begin
			want = due_results.pop_front();
			if (m_axis_tuser !== want.kind)
				report("kind", m_axis_tuser, want.kind);
			if (m_axis_tlast !== want.last)
				report("last", m_axis_tlast, want.last);
			if (m_axis_tdata[15:0] !== want.pc_now)
				report("pc_now", m_axis_tdata[15:0], want.pc_now);
			if (m_axis_tdata[18:16] !== want.cond_codes)
				report("cond_codes", m_axis_tdata[18:16], want.cond_codes);
			if (m_axis_tdata[21:19] !== want.reg_index)
				report("reg_index", m_axis_tdata[21:19], want.reg_index);
			if (m_axis_tdata[37:22] !== want.reg_value)
				report("reg_value", m_axis_tdata[37:22], want.reg_value);
			if (m_axis_tdata[39:38] !== 2'b00)
				report("tdata pad", m_axis_tdata[39:38], 2'b00);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
		end else begin
			if (cfg_wr_en) begin
				start_pc_q = cfg_wr_data;
			end
			// older results leave before the new item's results join the queue
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					MODE_LOAD:    mem_words[wrap(s_axis_tdata[15:0])] = s_axis_tdata[31:16];
					MODE_STEP:    execute_step();
					MODE_RESTART: begin
						pc_q = start_pc_q;
						halted_q = 1'b0;
					end
					default: ;
				endcase
			end
		end
		pending <= due_results.size();
	end

endmodule

// File: tb/lc3_instruction_executor_tb.sv
// Testbench top for the LC-3 executor: clock, reset, stimulus and verdict.
module lc3_instruction_executor_tb;
	import lc3x_pkg::*;

	localparam int ADDR_BITS      = 16;
	localparam int HALF_PERIOD    = 6;
	localparam int RANDOM_ITEMS   = 230;
	// longer than the slowest step (LDI) with margin
	localparam int SETTLE_CYCLES  = 16;
	// the memory sweep alone covers all 64K words of memory
	localparam int TIMEOUT_CYCLES = 1500000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 32'd0;   // [15:0] load_address, [31:16] load_data
	logic [1:0]  s_axis_tuser = 2'd0;    // [1:0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;           // [15:0] pc_now, [18:16] cond_codes,
	                                     // [21:19] reg_index, [37:22] reg_value
	logic [1:0]  m_axis_tuser;           // [1:0] kind
	logic        m_axis_tlast;

	int fail_count;
	int pending;
	int item_count = 0;
	int ready_left = 0;
	logic no_gaps = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	lc3_instruction_executor #(
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	lc3_instruction_executor_checker #(
		.ADDR_BITS(ADDR_BITS)
	) core_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Result side: alternating runs of ready and stall. Ready runs can be long enough for a
	// whole dump to go through unstalled; stalls are mostly short, now and then long, so they
	// land on every step phase and mid-dump.
	always @(posedge clk) begin
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else if ($urandom_range(99) < 60) begin
			m_axis_tready <= 1'b1;
			ready_left <= $urandom_range(60, 1);
		end else begin
			m_axis_tready <= 1'b0;
			ready_left <= ($urandom_range(99) < 80) ? $urandom_range(3, 1)
			                                         : $urandom_range(40, 10);
		end
	end

	// One item on the input side. tvalid stays high across back-to-back items;
	// it only drops when a gap is inserted, so it never sees two updates in one step.
	task automatic send_item(input logic [1:0] mode, input logic [15:0] addr,
			input logic [15:0] data);
		int gap;
		int pick;
		gap = 0;
		if (!no_gaps) begin
			pick = $urandom_range(99);
			if (pick >= 90) begin
				gap = $urandom_range(30, 8);
			end else if (pick >= 50) begin
				gap = $urandom_range(3, 1);
			end
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {data, addr};
		do @(posedge clk); while (!s_axis_tready);
		if (mode != MODE_UNUSED) begin
			item_count++;
		end
	endtask

	// Drain the core: every result back, then enough cycles for a load or
	// restart still in flight to finish (those produce no result to wait on).
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_pc(input logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Stray items that break up a program: unused mode, loads anywhere, restarts.
	task automatic noise_item();
		case ($urandom_range(2))
			0: send_item(MODE_UNUSED, 16'($urandom), 16'($urandom));
			1: send_item(MODE_LOAD, 16'($urandom), 16'($urandom));
			default: send_item(MODE_RESTART, 16'($urandom), 16'($urandom));
		endcase
	endtask

	// Random instruction word. Half of the pc-relative ones get a short offset
	// so control flow tends to stay inside the loaded program; a third of the
	// traps halt.
	function automatic logic [15:0] rand_instr();
		logic [15:0] ir;
		logic [15:0] near;
		ir = 16'($urandom);
		near = 16'($urandom_range(8) - 4);
		case (ir[15:12])
			OP_TRAP: begin
				if ($urandom_range(2) == 0) ir[7:0] = HALT_VECTOR;
			end
			OP_BR, OP_LD, OP_LDI, OP_ST, OP_STI, OP_LEA: begin
				if ($urandom_range(1) == 1) ir[8:0] = near[8:0];
			end
			OP_JSR: begin
				if (ir[11] && $urandom_range(1) == 1) ir[10:0] = near[10:0];
			end
			default: ;
		endcase
		return ir;
	endfunction

	initial begin
		logic [15:0] demo_prog [0:19];
		logic [15:0] prog_start;
		int prog_len;
		int random_goal;
		int i;

		// Directed program, loaded at 0xFFFF so it wraps to 0x0000.
		// Register values follow from the 0x7777 fill.
		demo_prog = '{
			{OP_ADD, 3'd1, 3'd0, 1'b1, 5'b10000},      // R1 = R0 - 16, imm5 extreme
			{OP_AND, 3'd2, 3'd1, 1'b1, 5'b01111},      // R2 = R1 & 15
			{OP_NOT, 3'd3, 3'd1, 6'b111111},           // R3 = ~R1, negative
			{OP_BR,  3'b100, 9'd1},                    // BRn, taken: skips the next word
			FILL_WORD,                                 // skipped; LD reads it back
			{OP_LD,  3'd4, 9'h1FE},                    // R4 = word above
			{OP_LDI, 3'd5, 9'h1FA},                    // pointer is the AND word
			{OP_LDR, 3'd6, 3'd5, 6'd31},               // R6 = mem[R5 + 31]
			{OP_ST,  3'd3, 9'h100},                    // offset9 extreme -256
			{OP_STI, 3'd2, 9'h1F9},                    // pointer is the BR word
			{OP_STR, 3'd4, 3'd3, 6'b100000},           // offset6 extreme -32
			{OP_JSR, 1'b1, 11'd1},                     // R7 = next, skip one word
			{OP_RES, 12'd0},                           // illegal, reached via JSRR
			{OP_JSR, 1'b0, 2'b00, 3'd7, 6'd0},         // JSRR R7 (target read first)
			{OP_LEA, 3'd6, 9'd1},                      // R6 = pc + 1, flags untouched
			{OP_JMP, 3'd0, 3'd6, 6'd0},                // jump over nothing, to R6
			{OP_BR,  3'b000, 9'd4},                    // no condition bits: never taken
			{OP_TRAP, 4'd0, 8'h20},                    // trap other than halt: no-op
			{OP_RTI, 12'd0},                           // illegal
			{OP_TRAP, 4'd0, HALT_VECTOR}               // halt and dump
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Fresh core: flags are clear, so even BRnzp falls through.
		// The next step runs unwritten memory (the fill word decodes as STR).
		// The load ahead of them waits out the memory sweep on tready.
		send_item(MODE_LOAD, 16'h0000, {OP_BR, 3'b111, 9'd5});
		send_item(MODE_STEP, 16'($urandom), 16'($urandom));
		send_item(MODE_STEP, 16'($urandom), 16'($urandom));
		send_item(MODE_UNUSED, 16'($urandom), 16'($urandom));

		quiesce();
		write_start_pc(16'hFFFF);
		send_item(MODE_RESTART, 16'($urandom), 16'($urandom));
		for (i = 0; i < 20; i++) begin
			send_item(MODE_LOAD, 16'hFFFF + i[15:0], demo_prog[i]);
		end
		// 20 executed steps follow the path above (JSRR runs twice, ending on
		// the halt), then one more step while halted
		for (i = 0; i < 21; i++) begin
			send_item(MODE_STEP, 16'($urandom), 16'($urandom));
		end

		// Random programs: restart, load a short program, step through it and a
		// bit past it, with stray items mixed in. start_pc changes only on a
		// drained core; the first setting is the low extreme.
		quiesce();
		prog_start = 16'h0000;
		write_start_pc(prog_start);
		random_goal = item_count + RANDOM_ITEMS;
		while (item_count < random_goal) begin
			no_gaps = ($urandom_range(3) == 0);
			if ($urandom_range(2) == 0) begin
				quiesce();
				case ($urandom_range(3))
					0: prog_start = 16'h0000;
					1: prog_start = 16'hFFFF;
					default: prog_start = 16'($urandom);
				endcase
				write_start_pc(prog_start);
			end
			send_item(MODE_RESTART, 16'($urandom), 16'($urandom));
			prog_len = $urandom_range(10, 3);
			for (i = 0; i < prog_len; i++) begin
				if ($urandom_range(9) == 0) noise_item();
				send_item(MODE_LOAD, prog_start + i[15:0], rand_instr());
			end
			for (i = 0; i < prog_len + 2; i++) begin
				if ($urandom_range(11) == 0) noise_item();
				send_item(MODE_STEP, 16'($urandom), 16'($urandom));
			end
		end

		// all results in, then a few idle cycles for anything trailing
		quiesce();
		if (fail_count == 0) begin
			$display("lc3_instruction_executor: match");
		end else begin
			$display("lc3_instruction_executor: mismatch");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
		$display("lc3_instruction_executor: mismatch");
		$finish;
	end

endmodule
